>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/swcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swcd_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOUD_LEVEL       = 3'd0,
        CFG_CRY_HOLD_MS      = 3'd1,
        CFG_MOTION_SPAN_MS   = 3'd2,
        CFG_MOTION_TRIPS     = 3'd3,
        CFG_LULLABY_LIMIT    = 3'd4,
        CFG_DEBOUNCE_MS      = 3'd5,
        CFG_TEST_MODE        = 3'd6
    } cfg_idx_t;

    localparam logic [11:0] RST_LOUD_LEVEL       = 12'd2000;
    localparam logic [31:0] RST_CRY_HOLD_MS      = 32'd5000;
    localparam logic [31:0] RST_MOTION_SPAN_MS   = 32'd10000;
    localparam logic [7:0]  RST_MOTION_TRIPS     = 8'd3;
    localparam logic [7:0]  RST_LULLABY_LIMIT    = 8'd3;
    localparam logic [15:0] RST_DEBOUNCE_MS      = 16'd50;

    localparam logic [7:0]  EDGE_COUNT_MAX       = 8'd255;

    typedef struct packed {
        logic [11:0] loud_level;
        logic [31:0] cry_hold_ms;
        logic [31:0] motion_span_ms;
        logic [7:0]  motion_trips;
        logic [7:0]  lullaby_limit;
        logic [15:0] debounce_ms;
        logic        test_mode;
    } cfg_t;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        button_level;
        logic        motion_level;
        logic [11:0] sound_sample;
        logic        playback_running;
    } in_t;

    typedef struct packed {
        logic       device_on;
        logic       warn_parent;
        logic       start_lullaby;
        logic       request_vibrate;
        logic       stop_playback;
        logic       alert_led;
        logic       test_motion;
        logic       test_sound;
        logic [7:0] lullabies_played;
    } out_t;

endpackage

`default_nettype wire

>>> rtl/swcd_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface swcd_in_if;
    import swcd_pkg::*;

    logic valid;
    logic ready;
    in_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/swcd_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface swcd_out_if;
    import swcd_pkg::*;

    logic valid;
    logic ready;
    out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/sensor_wake_cry_detector.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// Motion-armed cry detector that turns one sensor poll into one result beat.
// A poll is accepted in every cycle the output side keeps up; its result
// passes first through the input register and then through the result
// register. The rate of one poll per cycle, while the output side keeps up,
// is set by the state update, a combinational block of compares and counter
// steps between those two registers. Configuration writes take effect the cycle
// after cfg_we and are meant to happen while no beat is in flight.
module sensor_wake_cry_detector (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [swcd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [swcd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    swcd_in_if.sink                                 in_ch,
    swcd_out_if.source                              out_ch
);
    import swcd_pkg::*;

    cfg_t cfg;
    out_t res;

    logic s1_valid_reg, s1_valid_next;
    in_t  s1_data_reg;
    logic out_valid_reg, out_valid_next;
    out_t out_data_reg;
    logic advance;
    logic step;
    logic in_fire;

    assign advance      = !out_valid_reg || out_ch.ready;
    assign step         = s1_valid_reg && advance;
    assign in_ch.ready  = !s1_valid_reg || advance;
    assign in_fire      = in_ch.valid && in_ch.ready;

    swcd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    swcd_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .in_data (s1_data_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_data_reg <= in_ch.data;
        end
        if (step)
        begin
            out_data_reg <= res;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    // A lullaby or a vibrate request always comes with the warning.
    `ASSERT_IMPLIES(a_action_warns, clk, rst_n, out_valid_reg && (out_data_reg.start_lullaby || out_data_reg.request_vibrate), out_data_reg.warn_parent, "action beat without warning")
    // The two follow-up actions exclude each other.
    `ASSERT_ALWAYS(a_action_excl, clk, rst_n, !(out_valid_reg && out_data_reg.start_lullaby && out_data_reg.request_vibrate), "lullaby and vibrate in one beat")
    // Warnings are only raised while the block is on.
    `ASSERT_IMPLIES(a_warn_on, clk, rst_n, out_valid_reg && out_data_reg.warn_parent, out_data_reg.device_on, "warning while off")
    // A stalled result beat is never overwritten by a new step.
    `ASSERT_IMPLIES(a_no_overrun, clk, rst_n, out_valid_reg && !out_ch.ready, !step, "result overwritten while stalled")

endmodule

`default_nettype wire

>>> rtl/swcd_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module swcd_cfg (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [swcd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [swcd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output swcd_pkg::cfg_t                          cfg
);
    import swcd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LOUD_LEVEL:       cfg_next.loud_level       = cfg_wdata[11:0];
                CFG_CRY_HOLD_MS:      cfg_next.cry_hold_ms      = cfg_wdata[31:0];
                CFG_MOTION_SPAN_MS:   cfg_next.motion_span_ms   = cfg_wdata[31:0];
                CFG_MOTION_TRIPS:     cfg_next.motion_trips     = cfg_wdata[7:0];
                CFG_LULLABY_LIMIT:    cfg_next.lullaby_limit    = cfg_wdata[7:0];
                CFG_DEBOUNCE_MS:      cfg_next.debounce_ms      = cfg_wdata[15:0];
                CFG_TEST_MODE:        cfg_next.test_mode        = cfg_wdata[0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.loud_level       <= RST_LOUD_LEVEL;
            cfg_reg.cry_hold_ms      <= RST_CRY_HOLD_MS;
            cfg_reg.motion_span_ms   <= RST_MOTION_SPAN_MS;
            cfg_reg.motion_trips     <= RST_MOTION_TRIPS;
            cfg_reg.lullaby_limit    <= RST_LULLABY_LIMIT;
            cfg_reg.debounce_ms      <= RST_DEBOUNCE_MS;
            cfg_reg.test_mode        <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/swcd_core.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module swcd_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  swcd_pkg::in_t        in_data,
    input  swcd_pkg::cfg_t       cfg,
    output swcd_pkg::out_t       res
);
    import swcd_pkg::*;

    logic        prev_button_reg,   prev_button_next;
    logic        stable_button_reg, stable_button_next;
    logic [31:0] btn_change_reg,    btn_change_next;
    logic        is_on_reg,         is_on_next;
    logic        prev_motion_reg,   prev_motion_next;
    logic [7:0]  edge_count_reg,    edge_count_next;
    logic [31:0] window_begin_reg,  window_begin_next;
    logic        window_valid_reg,  window_valid_next;
    logic        wake_armed_reg,    wake_armed_next;
    logic        loud_now_reg,      loud_now_next;
    logic [31:0] loud_begin_reg,    loud_begin_next;
    logic [7:0]  played_reg,        played_next;

    logic        loud;
    logic        rose;
    logic        expired;
    logic [31:0] btn_age;
    logic [31:0] window_age;
    logic [31:0] loud_age;

    assign loud       = in_data.sound_sample > cfg.loud_level;
    assign window_age = in_data.now_ms - window_begin_reg;
    assign loud_age   = in_data.now_ms - loud_begin_reg;
    assign btn_age    = in_data.now_ms - btn_change_next;
    assign rose       = in_data.motion_level & ~prev_motion_reg;
    assign expired    = window_age > cfg.motion_span_ms;

    always_comb
    begin
        prev_button_next   = prev_button_reg;
        stable_button_next = stable_button_reg;
        is_on_next         = is_on_reg;
        prev_motion_next   = prev_motion_reg;
        edge_count_next    = edge_count_reg;
        window_begin_next  = window_begin_reg;
        window_valid_next  = window_valid_reg;
        wake_armed_next    = wake_armed_reg;
        loud_now_next      = loud_now_reg;
        loud_begin_next    = loud_begin_reg;
        played_next        = played_reg;
        res                = '0;

        btn_change_next = (in_data.button_level != prev_button_reg) ? in_data.now_ms
                                                                     : btn_change_reg;

        if (cfg.test_mode)
        begin
            btn_change_next = btn_change_reg;
            res.test_motion = in_data.motion_level;
            res.test_sound  = loud;
            res.alert_led   = is_on_reg & in_data.playback_running;
        end
        else
        begin
            // A press is a debounced fall of the button level.
            if (btn_age > {16'd0, cfg.debounce_ms}
                && in_data.button_level != stable_button_reg)
            begin
                stable_button_next = in_data.button_level;
                if (!in_data.button_level)
                begin
                    is_on_next = ~is_on_reg;
                    if (is_on_reg)
                    begin
                        edge_count_next   = '0;
                        window_begin_next = '0;
                        window_valid_next = 1'b0;
                        wake_armed_next   = 1'b0;
                        loud_now_next     = 1'b0;
                        loud_begin_next   = '0;
                        played_next       = '0;
                        res.stop_playback = in_data.playback_running;
                    end
                end
            end
            prev_button_next = in_data.button_level;

            if (is_on_next)
            begin
                prev_motion_next = in_data.motion_level;
                if (in_data.motion_level)
                begin
                    if (!window_valid_reg || expired)
                    begin
                        window_begin_next = in_data.now_ms;
                        window_valid_next = 1'b1;
                        edge_count_next   = '0;
                    end
                    if (rose)
                    begin
                        if (edge_count_next != EDGE_COUNT_MAX)
                        begin
                            edge_count_next = edge_count_next + 8'd1;
                        end
                        if (edge_count_next >= cfg.motion_trips)
                        begin
                            wake_armed_next = 1'b1;
                        end
                    end
                end
                else if (window_valid_reg && expired)
                begin
                    window_valid_next = 1'b0;
                    window_begin_next = '0;
                    edge_count_next   = '0;
                end

                if (wake_armed_next && !in_data.playback_running)
                begin
                    if (loud)
                    begin
                        if (!loud_now_reg)
                        begin
                            loud_now_next   = 1'b1;
                            loud_begin_next = in_data.now_ms;
                        end
                        else if (loud_age >= cfg.cry_hold_ms)
                        begin
                            res.warn_parent = 1'b1;
                            if (played_reg < cfg.lullaby_limit)
                            begin
                                played_next       = played_reg + 8'd1;
                                res.start_lullaby = 1'b1;
                            end
                            else
                            begin
                                res.request_vibrate = 1'b1;
                            end
                            loud_now_next     = 1'b0;
                            wake_armed_next   = 1'b0;
                            window_valid_next = 1'b0;
                            window_begin_next = '0;
                        end
                    end
                    else
                    begin
                        loud_now_next = 1'b0;
                    end
                end
                res.alert_led = res.start_lullaby | in_data.playback_running;
            end
        end

        res.device_on        = is_on_next;
        res.lullabies_played = played_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_button_reg   <= 1'b0;
            stable_button_reg <= 1'b0;
            btn_change_reg    <= '0;
            is_on_reg         <= 1'b0;
            prev_motion_reg   <= 1'b0;
            edge_count_reg    <= '0;
            window_begin_reg  <= '0;
            window_valid_reg  <= 1'b0;
            wake_armed_reg    <= 1'b0;
            loud_now_reg      <= 1'b0;
            loud_begin_reg    <= '0;
            played_reg        <= '0;
        end
        else if (step)
        begin
            prev_button_reg   <= prev_button_next;
            stable_button_reg <= stable_button_next;
            btn_change_reg    <= btn_change_next;
            is_on_reg         <= is_on_next;
            prev_motion_reg   <= prev_motion_next;
            edge_count_reg    <= edge_count_next;
            window_begin_reg  <= window_begin_next;
            window_valid_reg  <= window_valid_next;
            wake_armed_reg    <= wake_armed_next;
            loud_now_reg      <= loud_now_next;
            loud_begin_reg    <= loud_begin_next;
            played_reg        <= played_next;
        end
    end

    // Test mode must leave the detection state alone; the on state, lullaby count and edge count are checked.
    `ASSERT_NEXT(a_test_frozen, clk, rst_n, step && cfg.test_mode, $stable(is_on_reg) && $stable(played_reg) && $stable(edge_count_reg), "state changed in test mode")
    // Being off means the detection state was cleared.
    `ASSERT_IMPLIES(a_off_clear, clk, rst_n, !is_on_reg, !wake_armed_reg && played_reg == 8'd0 && !window_valid_reg, "detection state kept while off")
    // A confirmed cry needs an armed wake before the step.
    `ASSERT_IMPLIES(a_warn_armed, clk, rst_n, step && res.warn_parent, wake_armed_reg && loud_now_reg, "warning without armed wake")

endmodule

`default_nettype wire
